[rtl/brq_pkg.sv]
// ----------------------------------------------------------------------------
// brq_pkg: shared types and constants for the broadcast ring queue
// Ring sizes, opcode and status codes, command and monitor structs.
// ----------------------------------------------------------------------------
`default_nettype none

package brq_pkg;

  localparam int DEPTH       = 16;
  localparam int PTR_W       = $clog2(DEPTH);
  localparam int MAX_READERS = 8;
  localparam int RD_W        = 3;
  localparam int MSG_WIDTH   = 32;
  localparam int PEND_W      = $clog2(DEPTH + 1);
  localparam int TOTAL_W     = $clog2(MAX_READERS + 1);
  localparam int OP_W        = 3;
  localparam int ST_W        = 3;

  // opcodes
  localparam logic [OP_W-1:0] OP_SUB   = 3'd0;
  localparam logic [OP_W-1:0] OP_UNSUB = 3'd1;
  localparam logic [OP_W-1:0] OP_PUB   = 3'd2;
  localparam logic [OP_W-1:0] OP_FETCH = 3'd3;

  // result status codes
  localparam logic [ST_W-1:0] ST_OK      = 3'd0;
  localparam logic [ST_W-1:0] ST_DROPPED = 3'd1;
  localparam logic [ST_W-1:0] ST_FULL    = 3'd2;
  localparam logic [ST_W-1:0] ST_EMPTY   = 3'd3;
  localparam logic [ST_W-1:0] ST_NOSUB   = 3'd4;
  localparam logic [ST_W-1:0] ST_DUPSUB  = 3'd5;

  // decoded command class; unknown opcodes behave as a query
  typedef enum logic [2:0] {
    K_SUB,
    K_UNSUB,
    K_PUB,
    K_FETCH,
    K_QUERY
  } kind_t;

  typedef struct packed {
    kind_t                kind;
    logic [RD_W-1:0]      reader;
    logic [MSG_WIDTH-1:0] payload;
  } cmd_t;

  // back end status seen by the top level checks
  typedef struct packed {
    logic                busy;
    logic                res_valid;
    logic                ring_empty;
    logic                head_eq_tail;
    logic [TOTAL_W-1:0]  total;
    logic [MAX_READERS-1:0] valid;
  } mon_t;

endpackage

`default_nettype wire

[rtl/brq_if.sv]
// ----------------------------------------------------------------------------
// brq_if: request and result channels
// Valid/ready channels carrying the operation and its result.
// ----------------------------------------------------------------------------
`default_nettype none

interface brq_in_if import brq_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [OP_W-1:0]      opcode;
  logic [RD_W-1:0]      reader;
  logic [MSG_WIDTH-1:0] payload;

  modport source (output valid, output opcode, output reader, output payload, input ready);
  modport sink (input valid, input opcode, input reader, input payload, output ready);
endinterface

interface brq_out_if import brq_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [ST_W-1:0]      status;
  logic [MSG_WIDTH-1:0] message;
  logic [PEND_W-1:0]    pending;

  modport source (output valid, output status, output message, output pending, input ready);
  modport sink (input valid, input status, input message, input pending, output ready);
endinterface

`default_nettype wire

[rtl/broadcast_ring_queue.sv]
// Query, subscribe, dropped publish, empty fetch and unsubscribe of a free
// slot register their result straight from idle; fetch passes through
// S_FETCH and publish through S_PUB; a publish to a full ring first walks
// S_RECLAIM over the read head slots, an unsubscribe walks S_DRAIN over its
// pending messages. One operation runs at a time; the two-entry command
// queue takes requests while not full. Reset spares message and result data.
// ----------------------------------------------------------------------------
// broadcast_ring_queue: multi-reader broadcast ring buffer
// Front end queues classified requests, back end runs them on the ring.
// ----------------------------------------------------------------------------
`default_nettype none

module broadcast_ring_queue import brq_pkg::*; (
  input wire logic  clk,
  input wire logic  rst,
  brq_in_if.sink    in_ch,
  brq_out_if.source out_ch
);

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_ready;
  mon_t mon;

  brq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready)
  );

  brq_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .out_ch    (out_ch),
    .mon       (mon)
  );

  // subscriber count tracks the valid bits
  a_total: assert property (@(posedge clk) disable iff (rst)
    mon.total == TOTAL_W'($countones(mon.valid)))
    else $error("subscriber count mismatch");

  // an empty ring has head and tail together
  a_empty: assert property (@(posedge clk) disable iff (rst)
    mon.ring_empty |-> mon.head_eq_tail)
    else $error("empty ring with head away from tail");

  // a multi-cycle operation only runs with the result register free
  a_busy: assert property (@(posedge clk) disable iff (rst)
    mon.busy |-> !mon.res_valid)
    else $error("result pending during operation");

endmodule

`default_nettype wire

[rtl/brq_front.sv]
// ----------------------------------------------------------------------------
// brq_front: request intake
// Classifies each request and holds it in a two-entry command queue.
// ----------------------------------------------------------------------------
`default_nettype none

module brq_front import brq_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  brq_in_if.sink    in_ch,
  output cmd_t      cmd,
  output logic      cmd_valid,
  input  wire logic cmd_ready
);

  cmd_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;
  cmd_t       dec;

  // opcode classification
  always_comb begin
    dec.reader  = in_ch.reader;
    dec.payload = in_ch.payload;
    unique case (in_ch.opcode)
      OP_SUB:   dec.kind = K_SUB;
      OP_UNSUB: dec.kind = K_UNSUB;
      OP_PUB:   dec.kind = K_PUB;
      OP_FETCH: dec.kind = K_FETCH;
      default:  dec.kind = K_QUERY;
    endcase
  end

  assign in_ch.ready = (count != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign cmd_valid   = (count != 2'd0);
  assign pop         = cmd_valid && cmd_ready;
  assign cmd         = q[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= dec;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

`default_nettype wire

[rtl/brq_back.sv]
// ----------------------------------------------------------------------------
// brq_back: operation sequencer
// Carries out one command at a time on the ring and reader tables.
// ----------------------------------------------------------------------------
`default_nettype none

module brq_back import brq_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire cmd_t  cmd,
  input  wire logic  cmd_valid,
  output logic       cmd_ready,
  brq_out_if.source  out_ch,
  output mon_t       mon
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_RECLAIM = 3'd1;
  localparam logic [2:0] S_PUB     = 3'd2;
  localparam logic [2:0] S_DRAIN   = 3'd3;
  localparam logic [2:0] S_FETCH   = 3'd4;

  localparam logic [PEND_W-1:0] PEND_MAX = PEND_W'(DEPTH);

  logic [2:0]           state;
  cmd_t                 cur;
  logic [PTR_W-1:0]     head;
  logic [PTR_W-1:0]     tail;
  logic                 ring_empty;
  logic [MAX_READERS-1:0] rvalid;
  logic [PTR_W-1:0]     rptr  [MAX_READERS];
  logic [PEND_W-1:0]    rpend [MAX_READERS];
  logic [TOTAL_W-1:0]   total;
  logic [TOTAL_W-1:0]   unread [DEPTH];
  logic [MSG_WIDTH-1:0] mem [DEPTH];
  logic [MSG_WIDTH-1:0] rd_data;
  logic                 res_valid;
  logic [ST_W-1:0]      res_status;
  logic [MSG_WIDTH-1:0] res_message;
  logic [PEND_W-1:0]    res_pending;

  logic             pop;
  logic             full;
  logic             mem_we;
  logic             mem_re;
  logic [RD_W-1:0]  r;
  logic [PTR_W-1:0] rp;
  logic [PTR_W-1:0] head_inc;

  assign pop       = (state == S_IDLE) && cmd_valid && (!res_valid || out_ch.ready);
  assign cmd_ready = pop;
  assign r         = cur.reader;
  assign rp        = rptr[r];
  assign full      = !ring_empty && (head == tail);
  assign head_inc  = head + PTR_W'(1);
  assign mem_we    = (state == S_PUB) && !full;
  assign mem_re    = pop && (cmd.kind == K_FETCH);

  assign out_ch.valid   = res_valid;
  assign out_ch.status  = res_status;
  assign out_ch.message = res_message;
  assign out_ch.pending = res_pending;

  assign mon.busy         = (state != S_IDLE);
  assign mon.res_valid    = res_valid;
  assign mon.ring_empty   = ring_empty;
  assign mon.head_eq_tail = (head == tail);
  assign mon.total        = total;
  assign mon.valid        = rvalid;

  // message store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[tail] <= cur.payload;
    end
    if (mem_re) begin
      rd_data <= mem[rptr[cmd.reader]];
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (state == S_IDLE && pop) begin
      res_message <= '0;
      unique case (cmd.kind)
        K_SUB: begin
          res_status  <= rvalid[cmd.reader] ? ST_DUPSUB : ST_OK;
          res_pending <= rvalid[cmd.reader] ? rpend[cmd.reader] : '0;
        end
        K_PUB: begin
          res_status  <= ST_DROPPED;
          res_pending <= rvalid[cmd.reader] ? rpend[cmd.reader] : '0;
        end
        K_UNSUB: begin
          res_status  <= ST_NOSUB;
          res_pending <= '0;
        end
        K_FETCH: begin
          res_status  <= rvalid[cmd.reader] ? ST_EMPTY : ST_NOSUB;
          res_pending <= '0;
        end
        default: begin
          res_status  <= rvalid[cmd.reader] ? ST_OK : ST_NOSUB;
          res_pending <= rvalid[cmd.reader] ? rpend[cmd.reader] : '0;
        end
      endcase
    end else if (state == S_PUB) begin
      res_message <= '0;
      if (full) begin
        res_status  <= ST_FULL;
        res_pending <= rvalid[r] ? rpend[r] : '0;
      end else begin
        res_status  <= ST_OK;
        res_pending <= !rvalid[r] ? '0 :
                       (rpend[r] < PEND_MAX) ? rpend[r] + PEND_W'(1) : rpend[r];
      end
    end else if (state == S_DRAIN) begin
      res_status  <= ST_OK;
      res_message <= '0;
      res_pending <= '0;
    end else if (state == S_FETCH) begin
      res_status  <= ST_OK;
      res_message <= rd_data;
      res_pending <= rpend[r] - PEND_W'(1);
    end
  end

  // sequencer and table updates
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      head       <= '0;
      tail       <= '0;
      ring_empty <= 1'b1;
      rvalid     <= '0;
      total      <= '0;
      res_valid  <= 1'b0;
      for (int i = 0; i < MAX_READERS; i++) begin
        rptr[i]  <= '0;
        rpend[i] <= '0;
      end
      for (int i = 0; i < DEPTH; i++) begin
        unread[i] <= '0;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (pop) begin
            cur <= cmd;
            unique case (cmd.kind)
              K_SUB: begin
                res_valid <= 1'b1;
                if (!rvalid[cmd.reader]) begin
                  rvalid[cmd.reader] <= 1'b1;
                  rptr[cmd.reader]   <= tail;
                  rpend[cmd.reader]  <= '0;
                  total              <= total + TOTAL_W'(1);
                end
              end
              K_PUB: begin
                if (total == '0) begin
                  res_valid <= 1'b1;
                end else if (full) begin
                  res_valid <= 1'b0;
                  state     <= S_RECLAIM;
                end else begin
                  res_valid <= 1'b0;
                  state     <= S_PUB;
                end
              end
              K_UNSUB: begin
                if (rvalid[cmd.reader]) begin
                  res_valid <= 1'b0;
                  state     <= S_DRAIN;
                end else begin
                  res_valid <= 1'b1;
                end
              end
              K_FETCH: begin
                if (rvalid[cmd.reader] && rpend[cmd.reader] != '0) begin
                  res_valid <= 1'b0;
                  state     <= S_FETCH;
                end else begin
                  res_valid <= 1'b1;
                end
              end
              default: begin
                res_valid <= 1'b1;
              end
            endcase
          end else if (res_valid && out_ch.ready) begin
            res_valid <= 1'b0;
          end
        end
        // free head slots every reader has read, one per cycle
        S_RECLAIM: begin
          if (!ring_empty && unread[head] == '0) begin
            head <= head_inc;
            if (head_inc == tail) begin
              ring_empty <= 1'b1;
            end
          end else begin
            state <= S_PUB;
          end
        end
        S_PUB: begin
          res_valid <= 1'b1;
          state     <= S_IDLE;
          if (!full) begin
            if (ring_empty) begin
              head <= tail;
            end
            ring_empty   <= 1'b0;
            unread[tail] <= total;
            tail         <= tail + PTR_W'(1);
            for (int i = 0; i < MAX_READERS; i++) begin
              if (rvalid[i] && rpend[i] < PEND_MAX) begin
                rpend[i] <= rpend[i] + PEND_W'(1);
              end
            end
          end
        end
        // walk the leaving reader's unread slots
        S_DRAIN: begin
          if (rpend[r] != '0) begin
            if (unread[rp] != '0) begin
              unread[rp] <= unread[rp] - TOTAL_W'(1);
            end
            rptr[r]  <= rp + PTR_W'(1);
            rpend[r] <= rpend[r] - PEND_W'(1);
          end else begin
            rvalid[r] <= 1'b0;
            if (total != '0) begin
              total <= total - TOTAL_W'(1);
            end
            res_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        S_FETCH: begin
          if (unread[rp] != '0) begin
            unread[rp] <= unread[rp] - TOTAL_W'(1);
          end
          rptr[r]   <= rp + PTR_W'(1);
          rpend[r]  <= rpend[r] - PEND_W'(1);
          res_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
